// ----- rtl/core/bvg_pkg.sv -----
// Shared constants, types and the threshold table of the battery voltage gauge.
// Used by every module of the gauge; depends on nothing else.
package bvg_pkg;

  localparam int VOLT_W = 16;
  localparam int AGE_W  = 16;
  localparam int SUM_W  = 26;
  localparam int CNT_W  = 10;
  localparam int CAP_W  = 7;

  localparam logic [AGE_W-1:0] STALE_LIMIT_RESET = AGE_W'(2000);

  // The block length is an odd factor times a power of two, so the average is a
  // shift followed by a reciprocal multiplication.
  localparam int BLOCK_SHIFT   = 3;
  localparam int BLOCK_ODD     = 75;
  localparam int BLOCK_SAMPLES = BLOCK_ODD << BLOCK_SHIFT;

  localparam int QUOT_W      = SUM_W - BLOCK_SHIFT;
  localparam int ODD_BITS    = $clog2(BLOCK_ODD);
  localparam int RECIP_SHIFT = QUOT_W + ODD_BITS;
  localparam int RECIP_W     = RECIP_SHIFT - ODD_BITS + 1;
  localparam int PROD_W      = QUOT_W + RECIP_W;
  localparam longint RECIP_MUL =
      ((longint'(1) << RECIP_SHIFT) + longint'(BLOCK_ODD) - 1) / longint'(BLOCK_ODD);

  localparam int TABLE_SIZE    = 21;
  localparam int LEVELS        = 21;
  localparam int ACTIVE_LEVELS = (LEVELS < TABLE_SIZE) ? LEVELS : TABLE_SIZE;
  localparam int LVL_W         = $clog2(TABLE_SIZE);
  localparam int PERCENT_STEP  = 5;

  typedef logic [VOLT_W-1:0] volt_t;

  // Conversion request from the accumulator to the level stage.
  typedef struct packed {
    logic  valid;
    volt_t mv;
  } conv_t;

  function automatic volt_t threshold(input logic [LVL_W-1:0] idx);
    volt_t thr;
    case (idx)
      5'd0:    thr = 16'd38000;
      5'd1:    thr = 16'd38875;
      5'd2:    thr = 16'd39750;
      5'd3:    thr = 16'd40625;
      5'd4:    thr = 16'd41500;
      5'd5:    thr = 16'd42050;
      5'd6:    thr = 16'd42600;
      5'd7:    thr = 16'd43150;
      5'd8:    thr = 16'd43700;
      5'd9:    thr = 16'd44250;
      5'd10:   thr = 16'd44800;
      5'd11:   thr = 16'd45350;
      5'd12:   thr = 16'd45900;
      5'd13:   thr = 16'd46450;
      5'd14:   thr = 16'd47000;
      5'd15:   thr = 16'd47550;
      5'd16:   thr = 16'd48100;
      5'd17:   thr = 16'd48450;
      5'd18:   thr = 16'd48800;
      5'd19:   thr = 16'd49150;
      5'd20:   thr = 16'd49500;
      default: thr = '1;
    endcase
    return thr;
  endfunction

endpackage

// ----- rtl/core/battery_voltage_block_average_gauge_core.sv -----
// Top level of the battery voltage gauge: input register, result register,
// stale limit register. Depends on bvg_pkg, bvg_accum and bvg_level.
//
// Each accepted word (battery voltage in mV, sample age in ms) yields exactly one
// result word. The result holds the capacity estimate in percent and a flag that is
// set when this sample caused a table conversion. While the output side keeps up, a
// word is taken every clock cycle. After acceptance the word is held in the input
// register, then passes once through the sum, block average and threshold compare
// into the result register. While a result is not taken and the input register is
// full, the block holds two words and tready stays low. The stale limit resets to
// 2000 ms and should be written only while the block holds no word in flight.
module battery_voltage_block_average_gauge_core
  import bvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // stale_limit_ms
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // battery_mv [15:0], sample_age_ms [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // capacity_percent [6:0], zero [7]
  output logic        m_axis_tuser    // updated
);

  logic [AGE_W-1:0] stale_limit;

  logic             in_valid;
  volt_t            in_mv;
  logic [AGE_W-1:0] in_age;

  logic             out_valid;
  logic [CAP_W-1:0] out_cap;
  logic             out_updated;

  logic             step;
  conv_t            conv;
  logic [CAP_W-1:0] cap_next;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        stale_limit <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mv  <= s_axis_tdata[VOLT_W-1:0];
      in_age <= s_axis_tdata[VOLT_W +: AGE_W];
    end
    if (step) begin
      out_cap     <= cap_next;
      out_updated <= conv.valid;
    end
  end

  bvg_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .mv          (in_mv),
    .age         (in_age),
    .stale_limit (stale_limit),
    .conv        (conv)
  );

  bvg_level u_level (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .conv     (conv),
    .cap_next (cap_next)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_cap};
  assign m_axis_tuser  = out_updated;

endmodule

// ----- rtl/core/bvg_accum.sv -----
// Running voltage sum and sample count with the block average.
// Depends on bvg_pkg.
module bvg_accum
  import bvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  volt_t             mv,
  input  logic [AGE_W-1:0]  age,
  input  logic [AGE_W-1:0]  stale_limit,
  output conv_t             conv
);

  logic [SUM_W-1:0]   voltage_sum;
  logic [SUM_W-1:0]   voltage_sum_next;
  logic [CNT_W-1:0]   sample_count;
  logic [CNT_W-1:0]   sample_count_next;

  logic               fresh;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   cnt_add;
  logic [QUOT_W-1:0]  quot_in;
  logic [PROD_W-1:0]  prod;
  volt_t              avg;

  assign fresh   = age < stale_limit;
  assign sum_add = voltage_sum + SUM_W'(mv);
  assign cnt_add = sample_count + CNT_W'(1);

  // Divide by the block length: drop the power-of-two factor, then multiply by
  // the rounded-up reciprocal of the odd factor.
  assign quot_in = sum_add[SUM_W-1:BLOCK_SHIFT];
  assign prod    = PROD_W'(quot_in) * PROD_W'(RECIP_MUL[RECIP_W-1:0]);
  assign avg     = prod[RECIP_SHIFT +: VOLT_W];

  always_comb begin
    voltage_sum_next  = sum_add;
    sample_count_next = cnt_add;
    conv.valid        = 1'b0;
    conv.mv           = sum_add[VOLT_W-1:0];
    if (!fresh) begin
      voltage_sum_next  = '0;
      sample_count_next = '0;
    end else if (cnt_add == CNT_W'(BLOCK_SAMPLES)) begin
      // The average seeds the next block as a block of one sample.
      voltage_sum_next  = SUM_W'(avg);
      sample_count_next = CNT_W'(1);
      conv.valid        = 1'b1;
      conv.mv           = avg;
    end else if (cnt_add == CNT_W'(1)) begin
      conv.valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_sum  <= '0;
      sample_count <= '0;
    end else if (step) begin
      voltage_sum  <= voltage_sum_next;
      sample_count <= sample_count_next;
    end
  end

  a_count_below_block: assert property (@(posedge clk) disable iff (rst)
    sample_count < CNT_W'(BLOCK_SAMPLES))
    else $error("sample count reached the block length");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (sample_count == '0) |-> (voltage_sum == '0))
    else $error("sum not cleared with the count");

  a_stale_clears: assert property (@(posedge clk) disable iff (rst)
    (step && !fresh) |=> (sample_count == '0))
    else $error("stale sample did not clear the count");

endmodule

// ----- rtl/core/bvg_level.sv -----
// Threshold conversion and the held capacity register.
// Depends on bvg_pkg for the threshold table and the conversion request type.
module bvg_level
  import bvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  conv_t             conv,
  output logic [CAP_W-1:0]  cap_next
);

  logic [CAP_W-1:0]         held_capacity;
  logic [ACTIVE_LEVELS-1:0] hit;
  logic [LVL_W-1:0]         idx;
  logic                     found;

  always_comb begin
    for (int i = 0; i < ACTIVE_LEVELS; i++) begin
      hit[i] = conv.mv >= threshold(LVL_W'(i));
    end
  end

  // Highest threshold met wins.
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < ACTIVE_LEVELS; i++) begin
      if (hit[i]) begin
        idx   = LVL_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    cap_next = held_capacity;
    if (conv.valid && found) begin
      cap_next = CAP_W'(idx) * CAP_W'(PERCENT_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_capacity <= '0;
    end else if (step) begin
      held_capacity <= cap_next;
    end
  end

endmodule

// ----- test/battery_voltage_block_average_gauge_core_test.sv -----
// Self-checking testbench for the battery voltage block-average gauge core.
// Depends on bvg_pkg and battery_voltage_block_average_gauge_core; reads no files.
// A scoreboard class predicts every result word and checks the output stream.
module battery_voltage_block_average_gauge_core_test
  import bvg_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CAP_W-1:0] pct;
    logic             updated;
  } gauge_result_t;

  class gauge_scoreboard;
    logic [AGE_W-1:0]  stale_limit;
    logic [CAP_W-1:0]  held_pct;
    logic [SUM_W-1:0]  mv_sum;
    logic [CNT_W-1:0]  n_samples;
    int unsigned       level_mv [TABLE_SIZE];
    gauge_result_t     expected_q [$];
    int                errors;
    int                samples_seen;
    int                conversions;
    int                block_avgs;
    int                stale_seen;

    function new();
      level_mv = '{38000, 38875, 39750, 40625, 41500, 42050, 42600, 43150, 43700,
                   44250, 44800, 45350, 45900, 46450, 47000, 47550, 48100, 48450,
                   48800, 49150, 49500};
      stale_limit  = STALE_LIMIT_RESET;
      held_pct     = '0;
      mv_sum       = '0;
      n_samples    = '0;
      errors       = 0;
      samples_seen = 0;
      conversions  = 0;
      block_avgs   = 0;
      stale_seen   = 0;
    endfunction

    function void set_stale_limit(input logic [AGE_W-1:0] limit);
      stale_limit = limit;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predicts the result word of one accepted sample and queues it.
    function void note_sample(input logic [VOLT_W-1:0] mv, input logic [AGE_W-1:0] age);
      gauge_result_t     res;
      logic [31:0]       avg;
      logic [VOLT_W-1:0] conv_mv;
      logic              do_conv;
      logic              found;
      int                i;
      do_conv = 1'b0;
      conv_mv = '0;
      found   = 1'b0;
      samples_seen++;
      if (age < stale_limit) begin
        mv_sum    = mv_sum + SUM_W'(mv);
        n_samples = n_samples + 1'b1;
      end else begin
        mv_sum    = '0;
        n_samples = '0;
        stale_seen++;
      end
      if (n_samples >= BLOCK_SAMPLES) begin
        avg       = 32'(mv_sum) / 32'(n_samples);
        mv_sum    = SUM_W'(avg[VOLT_W-1:0]);
        n_samples = CNT_W'(1);
        conv_mv   = avg[VOLT_W-1:0];
        do_conv   = 1'b1;
        block_avgs++;
      end else if (n_samples == CNT_W'(1)) begin
        conv_mv = mv_sum[VOLT_W-1:0];
        do_conv = 1'b1;
      end
      if (do_conv) begin
        conversions++;
        // Below the lowest threshold the held value is kept.
        for (i = ACTIVE_LEVELS - 1; i >= 0; i--) begin
          if (!found && 32'(conv_mv) >= level_mv[i]) begin
            held_pct = CAP_W'(i * PERCENT_STEP);
            found    = 1'b1;
          end
        end
      end
      res.pct     = held_pct;
      res.updated = do_conv;
      expected_q.push_back(res);
    endfunction

    function void check_result(input logic [CAP_W-1:0] pct, input logic pad,
                               input logic updated);
      gauge_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with no sample pending: capacity %0d updated %0b",
                 $time, pct, updated);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (pct !== exp_res.pct) begin
        $display("%0t: capacity_percent expected %0d actual %0d", $time, exp_res.pct, pct);
        errors++;
      end
      if (updated !== exp_res.updated) begin
        $display("%0t: updated expected %0b actual %0b", $time, exp_res.updated, updated);
        errors++;
      end
      if (pad !== 1'b0) begin
        $display("%0t: tdata pad bit expected 0 actual %0b", $time, pad);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // battery_mv [15:0], sample_age_ms [31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // capacity_percent [6:0], zero [7]
  logic        m_axis_tuser;         // updated

  gauge_scoreboard gauge_sb = new();
  int cycle_count = 0;
  int sink_cycles = 0;
  int words_sent  = 0;

  battery_voltage_block_average_gauge_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("battery_voltage_block_average_gauge_core_test: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, a stretch with no stalls, then a long hold-off that fills the block.
  always @(posedge clk) begin
    sink_cycles <= sink_cycles + 1;
    if (sink_cycles >= 400 && sink_cycles < 460)
      m_axis_tready <= 1'b0;
    else if (sink_cycles >= 150 && sink_cycles < 350)
      m_axis_tready <= 1'b1;
    else
      m_axis_tready <= ($urandom_range(0, 99) >= 10);
  end

  // Sampled mid-cycle, so this word is taken at the coming rising edge.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      gauge_sb.check_result(m_axis_tdata[6:0], m_axis_tdata[7], m_axis_tuser);
  end

  task automatic send_sample(input logic [15:0] mv, input logic [15:0] age);
    while ($urandom_range(0, 99) < 10 && !(words_sent >= 200 && words_sent < 400)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {age, mv};
    do @(negedge clk); while (!s_axis_tready);
    gauge_sb.note_sample(mv, age);
    words_sent++;
    @(posedge clk);
  endtask

  // Stops the sender until every result has come and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (gauge_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stale_limit(input logic [15:0] limit);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    gauge_sb.set_stale_limit(limit);
  endtask

  function automatic logic [15:0] pick_voltage();
    if ($urandom_range(0, 9) < 2)
      return 16'($urandom);
    return 16'($urandom_range(37500, 50000));
  endfunction

  function automatic logic [15:0] pick_age(input logic [15:0] limit);
    if (limit != 0 && $urandom_range(0, 99) < 75)
      return 16'($urandom_range(0, limit - 1));
    if ($urandom_range(0, 3) == 0)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] edge_mv [10];
    logic [15:0] limits [4];
    logic [15:0] limit;
    int k;
    int j;
    edge_mv = '{16'd0, 16'd38000, 16'd38874, 16'd38875, 16'd44249, 16'd44250,
                16'd49499, 16'd49500, 16'd37999, 16'd65535};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a stale word before each fresh one, so every fresh word converts.
    for (k = 0; k < 10; k++) begin
      send_sample(16'($urandom), (k % 2 == 0) ? 16'd2000 : 16'hFFFF);
      send_sample(edge_mv[k], (k % 2 == 0) ? 16'd1999 : 16'd0);
    end
    send_sample(16'd30000, 16'd1999);

    // With a zero limit every sample is stale.
    write_stale_limit(16'd0);
    send_sample(16'd40000, 16'd0);
    send_sample(16'd50000, 16'hFFFF);
    send_sample(16'd0, 16'd1);

    // A long fresh run that closes at least one full block average.
    write_stale_limit(16'hFFFF);
    for (k = 0; k < 620; k++)
      send_sample(pick_voltage(), 16'($urandom_range(0, 65534)));

    // Mixed fresh and stale samples under several limits.
    limits = '{16'd1, 16'($urandom_range(2, 65534)), 16'd2000, 16'hFFFF};
    for (j = 0; j < 4; j++) begin
      limit = limits[j];
      write_stale_limit(limit);
      for (k = 0; k < 35; k++)
        send_sample(pick_voltage(), pick_age(limit));
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d samples: %0d conversions, %0d block averages, %0d stale samples.",
             gauge_sb.samples_seen, gauge_sb.conversions, gauge_sb.block_avgs,
             gauge_sb.stale_seen);
    $display("Stale limits covered 0, 1, 2000, 65535 and a random value.");
    if (gauge_sb.errors == 0 && gauge_sb.pending() == 0)
      $display("battery_voltage_block_average_gauge_core_test: PASS");
    else
      $display("battery_voltage_block_average_gauge_core_test: FAIL");
    $finish;
  end

endmodule
